// File: design/vsb_segment_sync_correlator_defines.svh
// Assertion macros for the segment sync correlator
`ifndef VSB_SEGMENT_SYNC_CORRELATOR_DEFINES_SVH
`define VSB_SEGMENT_SYNC_CORRELATOR_DEFINES_SVH

// Check a property on every clock edge outside reset
`define VSC_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check an implication in the next cycle
`define VSC_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) ante |=> cons) else $error(msg);

`endif

// File: design/vsc_pkg.sv
// Shared constants and types for the segment sync correlator
package vsc_pkg;
    localparam int SegLen   = 832;
    localparam int SlotW    = $clog2(SegLen);
    localparam int SymW     = 16;
    localparam int IntW     = 5;
    localparam int TimW     = 18;
    localparam int QDepth   = 2;
    localparam logic [3:0] SyncPattern = 4'h9;
    localparam logic signed [IntW-1:0] IntMin = -5'sd16;
    localparam logic signed [IntW-1:0] IntMax = 5'sd15;
    localparam logic [1:0] RegThreshold = 2'd0;
    localparam logic [1:0] RegOffset    = 2'd1;

    // One classified symbol passed from the front to the back
    typedef struct packed {
        logic signed [SymW-1:0] sym;
        logic [SlotW-1:0]       slot;
        logic                   match;
        logic                   wrap;
        logic                   first;
    } t_item;
endpackage

// File: design/vsc_ram.sv
// Generic single write, single read RAM with registered read data
module vsc_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: design/vsc_front.sv
// Front end: accept symbols, track sign history and slot, classify
module vsc_front import vsc_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic signed [SymW-1:0] i_symbol_in,
    output logic                   o_stall,
    input  logic                   i_q_full,
    output logic                   o_push,
    output t_item                  o_item
);
    logic [3:0]       r_hist, n_hist;
    logic [SlotW-1:0] r_slot;
    logic             r_first;
    logic             wrap;

    assign o_stall = i_q_full;
    assign o_push  = i_valid && !i_q_full;
    assign n_hist  = {~i_symbol_in[SymW-1], r_hist[3:1]};
    assign wrap    = (r_slot == SlotW'(SegLen - 1));

    always_comb begin
        o_item.sym   = i_symbol_in;
        o_item.slot  = r_slot;
        o_item.match = (n_hist == SyncPattern);
        o_item.wrap  = wrap;
        o_item.first = r_first;
    end

    // Advance history and slot on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist  <= '0;
            r_slot  <= '0;
            r_first <= 1'b1;
        end else if (o_push) begin
            r_hist <= n_hist;
            if (wrap) begin
                r_slot  <= '0;
                r_first <= 1'b0;
            end else begin
                r_slot <= r_slot + 1'b1;
            end
        end
    end
endmodule

// File: design/vsc_queue.sv
// Short FIFO between front and back
module vsc_queue import vsc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output t_item o_head,
    output logic  o_empty,
    output logic  o_full,
    output logic [$clog2(QDepth+1)-1:0] o_count
);
    localparam int PtrW = $clog2(QDepth);

    t_item                       r_buf [QDepth];
    logic [PtrW-1:0]             r_rd, r_wr;
    logic [$clog2(QDepth+1)-1:0] r_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == ($clog2(QDepth+1))'(QDepth));
    assign o_head  = r_buf[r_rd];
    assign o_count = r_count;

    // Store pushed beats
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr] <= i_item;
        end
    end

    // Move pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd    <= '0;
            r_wr    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PtrW'(QDepth - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PtrW'(QDepth - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end
endmodule

// File: design/vsc_back.sv
// Back end: integrator update, running best slot, lock, timing, output
module vsc_back import vsc_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_item                  i_head,
    input  logic                   i_q_empty,
    output logic                   o_pop,
    input  logic signed [IntW-1:0] i_threshold,
    input  logic [SlotW-1:0]       i_offset,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic signed [SymW-1:0] o_symbol_out,
    output logic [SlotW-1:0]       o_segment_pos,
    output logic                   o_data_valid,
    output logic                   o_segment_end,
    output logic                   o_timing_update,
    output logic signed [TimW-1:0] o_timing_error,
    output logic                   o_load
);
    localparam logic ST_RD = 1'b0;
    localparam logic ST_WR = 1'b1;

    logic                   r_state;
    t_item                  r_item;
    logic [IntW-1:0]        ram_rdata;
    logic                   load;
    logic signed [IntW-1:0] cur, v;
    logic signed [IntW:0]   sum;
    logic signed [SymW-1:0] r_s1, r_s2, r_s3;
    logic signed [IntW-1:0] r_best, n_best;
    logic [SlotW-1:0]       r_bi, n_bi;
    logic signed [TimW-1:0] r_part, n_part, fix, cand;
    logic signed [TimW-1:0] x, s1, s2, s3;
    logic                   r_lock, n_lock;
    logic [SlotW-1:0]       r_pos, n_pos, off, pos_inc;
    logic [SlotW:0]         pos_raw;
    logic signed [TimW-1:0] r_tim, n_tim;
    logic                   r_out_valid;

    assign o_pop = (r_state == ST_RD) && !i_q_empty;
    assign load  = (r_state == ST_WR) && (!r_out_valid || !i_stall);
    assign o_load = load;

    vsc_ram #(.Width(IntW), .Depth(SegLen)) u_int_ram (
        .i_clk   (i_clk),
        .i_we    (load),
        .i_waddr (r_item.slot),
        .i_wdata (v),
        .i_re    (o_pop),
        .i_raddr (i_head.slot),
        .o_rdata (ram_rdata)
    );

    // Integrator step with saturation; first segment reads the reset value
    always_comb begin
        cur = r_item.first ? IntMin : $signed(ram_rdata);
        sum = (IntW+1)'(cur) + (r_item.match ? (IntW+1)'(2) : -(IntW+1)'(1));
        if (sum > (IntW+1)'(IntMax)) begin
            v = IntMax;
        end else if (sum < (IntW+1)'(IntMin)) begin
            v = IntMin;
        end else begin
            v = sum[IntW-1:0];
        end
    end

    // Running best slot and the in-segment part of its timing error
    always_comb begin
        x  = TimW'(r_item.sym);
        s1 = TimW'(r_s1);
        s2 = TimW'(r_s2);
        s3 = TimW'(r_s3);
        if (r_item.slot >= SlotW'(3)) begin
            cand = s3 + s2 - s1 - x;
        end else if (r_item.slot == SlotW'(2)) begin
            cand = s2 - s1 - x;
        end else if (r_item.slot == SlotW'(1)) begin
            cand = -s1 - x;
        end else begin
            cand = -x;
        end
        n_best = r_best;
        n_bi   = r_bi;
        n_part = r_part;
        if (r_item.slot == '0 || v > r_best) begin
            n_best = v;
            n_bi   = r_item.slot;
            n_part = cand;
        end
    end

    // Segment end: finish timing error from the last samples, realign
    always_comb begin
        if (n_bi >= SlotW'(3)) begin
            fix = '0;
        end else if (n_bi == SlotW'(2)) begin
            fix = x;
        end else if (n_bi == SlotW'(1)) begin
            fix = x + s1;
        end else begin
            fix = -x + s1 + s2;
        end
        off = (i_offset > SlotW'(SegLen - 1)) ? SlotW'(SegLen - 1) : i_offset;
        pos_raw = {1'b0, off} + (SlotW+1)'(SegLen - 1) - {1'b0, n_bi};
        pos_inc = (r_pos == SlotW'(SegLen - 1)) ? '0 : r_pos + 1'b1;
        if (r_item.wrap) begin
            n_tim  = n_part + fix;
            n_lock = (n_best >= i_threshold);
            n_pos  = (pos_raw >= (SlotW+1)'(SegLen)) ?
                     SlotW'(pos_raw - (SlotW+1)'(SegLen)) : pos_raw[SlotW-1:0];
        end else begin
            n_tim  = r_tim;
            n_lock = r_lock;
            n_pos  = pos_inc;
        end
    end

    // Sequence: read integrator, then write back and load the output beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RD;
            r_out_valid <= 1'b0;
            r_lock      <= 1'b0;
            r_pos       <= '0;
            r_tim       <= '0;
            r_s1        <= '0;
            r_s2        <= '0;
            r_s3        <= '0;
            r_best      <= IntMin;
            r_bi        <= '0;
            r_part      <= '0;
        end else begin
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_RD: begin
                    if (o_pop) begin
                        r_state <= ST_WR;
                    end
                end
                ST_WR: begin
                    if (load) begin
                        r_state     <= ST_RD;
                        r_out_valid <= 1'b1;
                        r_lock      <= n_lock;
                        r_pos       <= n_pos;
                        r_tim       <= n_tim;
                        r_s1        <= r_item.sym;
                        r_s2        <= r_s1;
                        r_s3        <= r_s2;
                        r_best      <= n_best;
                        r_bi        <= n_bi;
                        r_part      <= n_part;
                    end
                end
                default: r_state <= ST_RD;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_head;
        end
        if (load) begin
            o_symbol_out    <= r_item.sym;
            o_timing_update <= r_item.wrap;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_segment_pos   = r_pos;
    assign o_data_valid    = r_lock;
    assign o_segment_end   = r_lock && (r_pos == SlotW'(SegLen - 1));
    assign o_timing_error  = r_tim;
endmodule

// File: design/vsb_segment_sync_correlator.sv
// Top level of the segment sync correlator
// Usage:
//   Input channel: i_valid / o_stall carry one symbol (i_symbol_in) a beat.
//   Output channel: o_valid / i_stall carry one result beat per symbol:
//   the symbol, its segment position, lock, segment end, timing update
//   flag and the latest timing error.
//   Configuration: APB write of lock_threshold at 0x0, index_offset at 0x4,
//   only while the block is idle; reads return the register values.
// Timing:
//   With no backlog, an accepted input beat passes through the queue, the
//   integrator read state and the write-back state before o_valid rises.
//   The back end reads the integrator RAM, then writes back, and pops no new
//   symbol until that write-back is done, which an output stall can hold.
//   Best slot is a running maximum, so segment end needs no separate pass.
// Reset: synchronous, active low. Lock, position and timing clear, and the
//   integrators read as their reset value for the first segment.
// Stall: a stalled result holds in the output register; the two-entry
//   queue fills, then o_stall rises until the receiver takes the beat.
module vsb_segment_sync_correlator import vsc_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic signed [SymW-1:0] i_symbol_in,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic signed [SymW-1:0] o_symbol_out,
    output logic [SlotW-1:0]       o_segment_pos,
    output logic                   o_data_valid,
    output logic                   o_segment_end,
    output logic                   o_timing_update,
    output logic signed [TimW-1:0] o_timing_error,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [2:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);
    `include "vsb_segment_sync_correlator_defines.svh"

    t_item                        push_item, head;
    logic                         push, pop, q_empty, q_full, back_load;
    logic [$clog2(QDepth+1)-1:0]  q_count;
    logic signed [IntW-1:0]       r_threshold;
    logic [SlotW-1:0]             r_offset;
    logic [1:0]                   reg_idx;

    // Register file
    assign pready  = 1'b1;
    assign reg_idx = {1'b0, paddr[2]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= 5'sd5;
            r_offset    <= SlotW'(3);
        end else if (psel && penable && pwrite) begin
            unique case (reg_idx)
                RegThreshold: r_threshold <= pwdata[IntW-1:0];
                RegOffset:    r_offset    <= pwdata[SlotW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            RegThreshold: prdata = 32'(r_threshold);
            RegOffset:    prdata = 32'(r_offset);
            default:      prdata = '0;
        endcase
    end

    vsc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_symbol_in (i_symbol_in),
        .o_stall     (o_stall),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_item      (push_item)
    );

    vsc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (q_empty),
        .o_full  (q_full),
        .o_count (q_count)
    );

    vsc_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (head),
        .i_q_empty       (q_empty),
        .o_pop           (pop),
        .i_threshold     (r_threshold),
        .i_offset        (r_offset),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_symbol_out    (o_symbol_out),
        .o_segment_pos   (o_segment_pos),
        .o_data_valid    (o_data_valid),
        .o_segment_end   (o_segment_end),
        .o_timing_update (o_timing_update),
        .o_timing_error  (o_timing_error),
        .o_load          (back_load)
    );

    // Checks
    `VSC_CHECK(a_q_bound, q_count <= ($clog2(QDepth+1))'(QDepth), "queue overflow")
    `VSC_CHECK(a_end_locked, o_segment_end |-> o_data_valid, "segment end without lock")
    `VSC_NEXT(a_load_shows, back_load, o_valid, "loaded beat not presented")
endmodule
